### hw/rtl/mer_pkg.sv
// shared types and constants of the midpoint ellipse rasterizer
// widths, register indexes, queue item and sequencer state codes
// no dependencies
package mer_pkg;

  localparam int COORD_BITS = 11;
  localparam int PIX_W      = 13;
  localparam int XW         = COORD_BITS + 1;
  localparam int YW         = COORD_BITS + 2;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int DEC_W      = 4 * COORD_BITS;
  localparam int MUL_W      = 2 * COORD_BITS + 3;
  localparam int IN_W       = 8;
  localparam int OUT_W      = ((2 * PIX_W + 7) / 8) * 8;

  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_CENTER_X    = 2'd0;
  localparam logic [CFG_AW-1:0] REG_CENTER_Y    = 2'd1;
  localparam logic [CFG_AW-1:0] REG_SEMI_AXIS_A = 2'd2;
  localparam logic [CFG_AW-1:0] REG_SEMI_AXIS_B = 2'd3;

  localparam int Q_AW    = 1;
  localparam int Q_DEPTH = 2 ** Q_AW;

  localparam logic [2:0] SEQ_INIT_LAST = 3'd3;
  localparam logic [2:0] SEQ_SEED_LAST = 3'd5;
  localparam logic [1:0] EMIT_LAST     = 2'd3;

  typedef enum logic [1:0] {
    PH_DONE,
    PH_REGION1,
    PH_REGION2
  } phase_t;

  typedef enum logic {
    KIND_STEP,
    KIND_RESTART
  } item_kind_t;

  typedef struct packed {
    logic       valid;
    item_kind_t kind;
  } q_head_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [COORD_BITS-1:0] a;
    logic [COORD_BITS-1:0] b;
  } geom_t;

  typedef enum logic [2:0] {
    WS_IDLE,
    WS_INIT,
    WS_STEP,
    WS_SEED,
    WS_EMIT
  } walk_state_t;

endpackage

### hw/rtl/midpoint_ellipse_rasterizer.sv
// top level of the midpoint ellipse rasterizer: configuration registers,
// input queue front end and walk engine
// depends on mer_pkg, mer_front, mer_walk
//
// Each input word is one plot step (restart in bit 0 reloads the walk from the
// semi-axis registers first); a live step gives four output words, the mirrored
// pixels (+x,+y) (-x,+y) (+x,-y) (-x,-y), tlast on the fourth and tuser on all
// four of the final step. A step word after completion gives nothing. A plain
// step is dequeued, updates the decision, then moves the four pixels through the
// single output register. A restart and the step that ends region 1 each add a
// sequence on the shared registered multiplier that forms the seeds. Up to two
// step words queue ahead of the walk.
module midpoint_ellipse_rasterizer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mer_pkg::IN_W-1:0]       in_tdata,   // [0] restart
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mer_pkg::OUT_W-1:0]      out_tdata,  // [12:0] pixel_x, [25:13] pixel_y
  output logic                           out_tlast,  // step_last
  output logic                           out_tuser,  // shape_done
  input  logic                           cfg_we,
  input  logic [mer_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [mer_pkg::COORD_BITS-1:0] cfg_wdata
);
  import mer_pkg::*;

  logic [COORD_BITS-1:0] cx_r, cy_r, sa_r, sb_r;
  geom_t                 geom;
  q_head_t               q_head;
  logic                  q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      sa_r <= COORD_BITS'(1);
      sb_r <= COORD_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CENTER_X:    cx_r <= cfg_wdata;
        REG_CENTER_Y:    cy_r <= cfg_wdata;
        REG_SEMI_AXIS_A: sa_r <= cfg_wdata;
        REG_SEMI_AXIS_B: sb_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign geom.cx = cx_r;
  assign geom.cy = cy_r;
  assign geom.a  = sa_r;
  assign geom.b  = sb_r;

  mer_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .head      (q_head),
    .pop       (q_pop)
  );

  mer_walk u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .pop        (q_pop),
    .geom       (geom),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

  a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> q_head.valid)
    else $error("accepted word missing from the queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("queue popped while empty");

endmodule

### hw/rtl/mer_front.sv
// front end: accepts input words, classifies them as restart or step
// and holds them in a two-entry queue for the walk engine
// depends on mer_pkg
module mer_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [mer_pkg::IN_W-1:0] in_tdata,  // [0] restart
  output mer_pkg::q_head_t      head,
  input  logic                  pop
);
  import mer_pkg::*;

  item_kind_t       kind_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r;
  logic [Q_AW-1:0]  rd_ptr_r;
  logic [Q_AW:0]    count_r;
  logic             push;
  item_kind_t       in_kind;

  assign in_tready = (count_r != (Q_AW + 1)'(Q_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign in_kind   = in_tdata[0] ? KIND_RESTART : KIND_STEP;

  assign head.valid = (count_r != '0);
  assign head.kind  = kind_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      kind_r[wr_ptr_r] <= in_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### hw/rtl/mer_walk.sv
// back end: midpoint ellipse walk with a shared registered multiplier
// for the restart and region-2 seeds, and a one-word output register
// depends on mer_pkg
module mer_walk (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mer_pkg::q_head_t         head,
  output logic                     pop,
  input  mer_pkg::geom_t           geom,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [mer_pkg::OUT_W-1:0] out_tdata,  // [12:0] pixel_x, [25:13] pixel_y
  output logic                     out_tlast,   // step_last
  output logic                     out_tuser    // shape_done
);
  import mer_pkg::*;

  walk_state_t             state_r, state_nxt;
  phase_t                  phase_r;
  logic [2:0]              seq_r;
  logic [1:0]              em_r;

  logic [XW-1:0]           x_r;
  logic signed [YW-1:0]    y_r;
  logic signed [DEC_W-1:0] dec_r;
  logic signed [DEC_W-1:0] px_r;
  logic signed [DEC_W-1:0] py_r;
  logic signed [DEC_W-1:0] acc_r;
  logic [SQ_W-1:0]         a2_r;
  logic [SQ_W-1:0]         b2_r;
  logic signed [MUL_W-1:0] tmp_r;
  logic signed [2*MUL_W-1:0] prod_r;

  logic [XW-1:0]           ex_r;
  logic signed [YW-1:0]    ey_r;
  logic                    edone_r;

  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_data_r;
  logic                    out_last_r;
  logic                    out_user_r;

  logic                    load;
  logic [COORD_BITS-1:0]   a_eff;
  logic [COORD_BITS-1:0]   b_eff;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [MUL_W-1:0] t_op, u_op;
  logic signed [YW-1:0]    y_dn;
  logic signed [DEC_W-1:0] a2_d, b2_d, p_d;
  logic signed [DEC_W-1:0] px_up, py_dn, diag;
  logic                    r1_go;
  logic [PIX_W-1:0]        pix_xp, pix_xn, pix_yp, pix_yn;
  logic [PIX_W-1:0]        pix_x, pix_y;

  assign a_eff = (geom.a == '0) ? COORD_BITS'(1) : geom.a;
  assign b_eff = (geom.b == '0) ? COORD_BITS'(1) : geom.b;

  assign y_dn = y_r - YW'(1);
  assign t_op = $signed(MUL_W'({x_r, 1'b1}));
  assign u_op = {{(MUL_W-YW){y_dn[YW-1]}}, y_dn};

  assign a2_d  = $signed(DEC_W'(a2_r));
  assign b2_d  = $signed(DEC_W'(b2_r));
  assign p_d   = prod_r[DEC_W-1:0];
  assign px_up = px_r + (b2_d <<< 1);
  assign py_dn = py_r - (a2_d <<< 1);
  assign diag  = px_up - py_dn;
  assign r1_go = (px_r < py_r);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == WS_INIT) begin
      unique case (seq_r)
        3'd0: begin
          mul_a = $signed(MUL_W'(a_eff));
          mul_b = $signed(MUL_W'(a_eff));
        end
        3'd1: begin
          mul_a = $signed(MUL_W'(b_eff));
          mul_b = $signed(MUL_W'(b_eff));
        end
        3'd2: begin
          mul_a = $signed(MUL_W'(a2_r));
          mul_b = $signed(MUL_W'(b_eff));
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end else if (state_r == WS_SEED) begin
      unique case (seq_r)
        3'd0: begin
          mul_a = t_op;
          mul_b = t_op;
        end
        3'd1: begin
          mul_a = u_op;
          mul_b = u_op;
        end
        3'd2: begin
          mul_a = $signed(MUL_W'(b2_r));
          mul_b = tmp_r;
        end
        3'd3: begin
          mul_a = $signed(MUL_W'(a2_r));
          mul_b = tmp_r;
        end
        3'd4: begin
          mul_a = $signed(MUL_W'(a2_r));
          mul_b = $signed(MUL_W'(b2_r));
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      WS_IDLE: begin
        if (head.valid) begin
          state_nxt = (head.kind == KIND_RESTART) ? WS_INIT : WS_STEP;
        end
      end
      WS_INIT: begin
        if (seq_r == SEQ_INIT_LAST) begin
          state_nxt = WS_STEP;
        end
      end
      WS_STEP: begin
        priority if (phase_r == PH_DONE) begin
          state_nxt = WS_IDLE;
        end else if (phase_r == PH_REGION1 && !r1_go) begin
          state_nxt = WS_SEED;
        end else begin
          state_nxt = WS_EMIT;
        end
      end
      WS_SEED: begin
        if (seq_r == SEQ_SEED_LAST) begin
          state_nxt = WS_EMIT;
        end
      end
      WS_EMIT: begin
        if (load && em_r == EMIT_LAST) begin
          state_nxt = WS_IDLE;
        end
      end
      default: state_nxt = WS_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    pop  = (state_r == WS_IDLE) && head.valid;
    load = (state_r == WS_EMIT) && (!out_valid_r || out_tready);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= WS_IDLE;
      phase_r     <= PH_DONE;
      seq_r       <= '0;
      em_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == WS_INIT || state_r == WS_SEED) begin
        seq_r <= seq_r + 3'd1;
      end else begin
        seq_r <= '0;
      end
      if (state_r == WS_INIT && seq_r == SEQ_INIT_LAST) begin
        phase_r <= PH_REGION1;
      end else if (state_r == WS_STEP) begin
        if (phase_r == PH_REGION1 && !r1_go) begin
          phase_r <= PH_REGION2;
        end else if (phase_r == PH_REGION2 && y_r == '0) begin
          phase_r <= PH_DONE;
        end
      end
      if (state_r == WS_STEP) begin
        em_r <= '0;
      end else if (load) begin
        em_r <= em_r + 2'd1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      WS_INIT: begin
        unique case (seq_r)
          3'd1: a2_r <= prod_r[SQ_W-1:0];
          3'd2: b2_r <= prod_r[SQ_W-1:0];
          3'd3: begin
            dec_r <= (b2_d <<< 2) - (p_d <<< 2) + a2_d;
            py_r  <= p_d <<< 1;
            px_r  <= '0;
            x_r   <= '0;
            y_r   <= $signed(YW'(b_eff));
          end
          default: ;
        endcase
      end
      WS_STEP: begin
        ex_r    <= x_r;
        ey_r    <= y_r;
        edone_r <= (phase_r == PH_REGION2) && (y_r == '0);
        if (phase_r == PH_REGION1 && r1_go) begin
          x_r  <= x_r + XW'(1);
          px_r <= px_up;
          if (dec_r < 0) begin
            dec_r <= dec_r + ((px_up + b2_d) <<< 2);
          end else begin
            y_r   <= y_dn;
            py_r  <= py_dn;
            dec_r <= dec_r + ((diag + b2_d) <<< 2);
          end
        end else if (phase_r == PH_REGION2) begin
          y_r  <= y_dn;
          py_r <= py_dn;
          if (dec_r > 0) begin
            dec_r <= dec_r + ((a2_d - py_dn) <<< 2);
          end else begin
            x_r   <= x_r + XW'(1);
            px_r  <= px_up;
            dec_r <= dec_r + ((diag + a2_d) <<< 2);
          end
        end
      end
      WS_SEED: begin
        unique case (seq_r)
          3'd1: tmp_r <= prod_r[MUL_W-1:0];
          3'd2: tmp_r <= prod_r[MUL_W-1:0];
          3'd3: acc_r <= p_d;
          3'd4: acc_r <= acc_r + (p_d <<< 2);
          3'd5: dec_r <= acc_r - (p_d <<< 2);
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // mirrored pixel select
  assign pix_xp = PIX_W'(geom.cx) + PIX_W'(ex_r);
  assign pix_xn = PIX_W'(geom.cx) - PIX_W'(ex_r);
  assign pix_yp = PIX_W'(geom.cy) + PIX_W'(ey_r);
  assign pix_yn = PIX_W'(geom.cy) - PIX_W'(ey_r);
  assign pix_x  = em_r[0] ? pix_xn : pix_xp;
  assign pix_y  = em_r[1] ? pix_yn : pix_yp;

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= OUT_W'({pix_y, pix_x});
      out_last_r <= (em_r == EMIT_LAST);
      out_user_r <= edone_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule
